@@ design/mpeg_audio_header_decoder_defines.svh @@
// Assertion macros for the MPEG audio header decoder.
// Used by the top level; depends on a clock named aclk and a reset named aresetn.
`ifndef MPEG_AUDIO_HEADER_DECODER_DEFINES_SVH
`define MPEG_AUDIO_HEADER_DECODER_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define MADH_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define MADH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/madh_pkg.sv @@
// Shared types, codes and rate tables of the MPEG audio header decoder.
// No dependencies; used by every module of the block.
package madh_pkg;

    // Header framing
    localparam logic [7:0] SYNC_BYTE      = 8'hFF;
    localparam int         HDR_W          = 32;
    localparam int         QUEUE_DEPTH_DEF = 2;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_SYNC = 2'd1;
    localparam logic [1:0] ST_RESERVED = 2'd2;

    // Raw header codes
    localparam logic [1:0] VER_MPEG1    = 2'd3;
    localparam logic [1:0] VER_RESERVED = 2'd1;
    localparam logic [1:0] LAY_I        = 2'd3;
    localparam logic [1:0] LAY_RESERVED = 2'd0;
    localparam logic [3:0] BRI_RESERVED = 4'd15;
    localparam logic [1:0] FRI_RESERVED = 2'd3;

    // Frame length arithmetic
    localparam int         FACTOR_W     = 18;
    localparam logic [FACTOR_W-1:0] FACTOR_LAYER_I = 18'd12000;
    localparam logic [FACTOR_W-1:0] FACTOR_OTHER   = 18'd144000;
    localparam int         KBPS_W       = 9;
    localparam int         HZ_W         = 16;
    localparam int         PROD_W       = FACTOR_W + KBPS_W;
    localparam int         LEN_W        = 12;

    // Bitrate rows: MPEG-1 I, II, III; MPEG-2/2.5 I; MPEG-2/2.5 II and III
    localparam logic [KBPS_W-1:0] KBPS_ROWS [0:4][0:15] = '{
        '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
          9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
        '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
          9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
        '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
          9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
        '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
          9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
        '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
          9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
    };

    // Sample rates by version code, then rate index
    localparam logic [HZ_W-1:0] HZ_ROWS [0:3][0:3] = '{
        '{16'd11025, 16'd12000, 16'd8000, 16'd0},
        '{16'd0, 16'd0, 16'd0, 16'd0},
        '{16'd22050, 16'd24000, 16'd16000, 16'd0},
        '{16'd44100, 16'd48000, 16'd32000, 16'd0}
    };

    // Back end sequencer
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV,
        BK_LEN,
        BK_DONE
    } back_state_t;

    // Queue status seen by both ends
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

@@ design/mpeg_audio_header_decoder.sv @@
// MPEG audio header decoder. The input takes one stream byte per cycle; bytes are
// dropped until a 0xFF byte, which with the next three bytes forms one header, and
// each header gives one result. The byte collector never stalls except on the last
// byte of a header while the header queue (QUEUE_DEPTH entries) is full. The decoder
// handles one header at a time: one with a valid, nonzero bitrate and rate passes pop,
// multiply, 27 steps of the one-bit-per-cycle frame length divider and length before
// its result is shown; any other header goes from pop straight to its result. The
// result stays on the output until taken. No clearing pass after reset.
`include "mpeg_audio_header_decoder_defines.svh"

module mpeg_audio_header_decoder #(
    parameter int QUEUE_DEPTH = madh_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [1:0]  m_version_code,
    output logic [1:0]  m_layer_code,
    output logic [8:0]  m_bitrate_kbps,
    output logic [15:0] m_sample_rate_hz,
    output logic [1:0]  m_channel_mode,
    output logic [1:0]  m_mode_extension,
    output logic [1:0]  m_emphasis,
    output logic [4:0]  m_flag_bits,
    output logic [11:0] m_frame_bytes
);

    logic                        push, pop;
    logic [madh_pkg::HDR_W-1:0]  push_data, head_data;
    madh_pkg::q_stat_t           q_stat;

    // Collect header bytes
    madh_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .q_stat      (q_stat),
        .push        (push),
        .push_data   (push_data)
    );

    // Hold headers between collector and decoder
    madh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head_data (head_data),
        .q_stat    (q_stat)
    );

    // Decode headers and compute frame length
    madh_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .head_data        (head_data),
        .q_stat           (q_stat),
        .pop              (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_version_code   (m_version_code),
        .m_layer_code     (m_layer_code),
        .m_bitrate_kbps   (m_bitrate_kbps),
        .m_sample_rate_hz (m_sample_rate_hz),
        .m_channel_mode   (m_channel_mode),
        .m_mode_extension (m_mode_extension),
        .m_emphasis       (m_emphasis),
        .m_flag_bits      (m_flag_bits),
        .m_frame_bytes    (m_frame_bytes)
    );

    `MADH_ASSERT_SAME(a_no_push_full, push, !q_stat.full, "header pushed into a full queue")
    `MADH_ASSERT_SAME(a_len_zero_not_ok, m_valid && (m_status != madh_pkg::ST_OK), m_frame_bytes == '0, "frame length on a failed header")
    `MADH_ASSERT_SAME(a_bad_sync_clear, m_valid && (m_status == madh_pkg::ST_BAD_SYNC), (m_bitrate_kbps == '0) && (m_sample_rate_hz == '0) && (m_flag_bits == '0), "fields left on a bad sync result")
    `MADH_ASSERT_SAME(a_len_needs_rate, m_valid && (m_frame_bytes != '0), (m_bitrate_kbps != '0) && (m_sample_rate_hz != '0), "frame length without bitrate or rate")

endmodule

@@ design/madh_front.sv @@
// Byte collector: hunts for the sync byte and assembles 32-bit headers.
// Depends on madh_pkg; pushes finished headers into the header queue.
module madh_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [7:0]                  s_data_byte,
    input  madh_pkg::q_stat_t           q_stat,
    output logic                        push,
    output logic [madh_pkg::HDR_W-1:0]  push_data
);

    logic [1:0]  count_reg, count_next;
    logic [23:0] hdr_reg, hdr_next;
    logic        accept;

    // Stall only on the last header byte when the queue has no room
    assign s_ready   = (count_reg != 2'd3) || !q_stat.full;
    assign accept    = s_valid && s_ready;
    assign push      = accept && (count_reg == 2'd3);
    assign push_data = {hdr_reg, s_data_byte};

    // Advance the byte count; drop bytes while hunting
    always_comb begin
        count_next = count_reg;
        hdr_next   = hdr_reg;
        if (accept) begin
            if (count_reg == 2'd0) begin
                if (s_data_byte == madh_pkg::SYNC_BYTE) begin
                    count_next = 2'd1;
                    hdr_next   = {16'd0, s_data_byte};
                end
            end else if (count_reg == 2'd3) begin
                count_next = 2'd0;
            end else begin
                count_next = count_reg + 2'd1;
                hdr_next   = {hdr_reg[15:0], s_data_byte};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
        hdr_reg <= hdr_next;
    end

endmodule

@@ design/madh_queue.sv @@
// Short header queue between the byte collector and the decoder.
// Depends on madh_pkg; head entry is read directly at the read pointer.
module madh_queue #(
    parameter int DEPTH = madh_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        push,
    input  logic [madh_pkg::HDR_W-1:0]  push_data,
    input  logic                        pop,
    output logic [madh_pkg::HDR_W-1:0]  head_data,
    output madh_pkg::q_stat_t           q_stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [madh_pkg::HDR_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]           wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]           rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]           fill_reg, fill_next;

    assign head_data    = entry_reg[rd_ptr_reg];
    assign q_stat.full  = (fill_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (fill_reg == '0);

    // Advance pointers with wrap at the queue depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store the pushed header
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ design/madh_back.sv @@
// Header decoder: table lookups, one multiply and a bit-serial divider
// for the frame length. Depends on madh_pkg; pops headers from the queue.
module madh_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [madh_pkg::HDR_W-1:0]  head_data,
    input  madh_pkg::q_stat_t           q_stat,
    output logic                        pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_status,
    output logic [1:0]                  m_version_code,
    output logic [1:0]                  m_layer_code,
    output logic [8:0]                  m_bitrate_kbps,
    output logic [15:0]                 m_sample_rate_hz,
    output logic [1:0]                  m_channel_mode,
    output logic [1:0]                  m_mode_extension,
    output logic [1:0]                  m_emphasis,
    output logic [4:0]                  m_flag_bits,
    output logic [11:0]                 m_frame_bytes
);

    localparam int PROD_W = madh_pkg::PROD_W;
    localparam int HZ_W   = madh_pkg::HZ_W;
    localparam int STEP_W = $clog2(PROD_W);

    madh_pkg::back_state_t state_reg, state_next;

    logic [1:0]                   status_reg, status_next;
    logic [1:0]                   ver_reg, ver_next;
    logic [1:0]                   lay_reg, lay_next;
    logic [madh_pkg::KBPS_W-1:0]  br_reg, br_next;
    logic [HZ_W-1:0]              fr_reg, fr_next;
    logic [1:0]                   cm_reg, cm_next;
    logic [1:0]                   me_reg, me_next;
    logic [1:0]                   emph_reg, emph_next;
    logic [4:0]                   flags_reg, flags_next;
    logic [madh_pkg::LEN_W-1:0]   len_reg, len_next;
    logic [PROD_W-1:0]            prod_reg, prod_next;
    logic [HZ_W-1:0]              rem_reg, rem_next;
    logic [madh_pkg::LEN_W-1:0]   quo_reg, quo_next;
    logic [STEP_W-1:0]            step_reg, step_next;

    // Decoded view of the queue head
    logic [1:0]                   h_ver, h_lay, h_fri;
    logic [3:0]                   h_bri;
    logic [2:0]                   h_row;
    logic                         h_sync_ok, h_reserved, h_need_div;
    logic [madh_pkg::KBPS_W-1:0]  h_br;
    logic [HZ_W-1:0]              h_fr;

    // Divider step
    logic [HZ_W:0]                rem_try;
    logic                         rem_ge;
    logic [madh_pkg::FACTOR_W-1:0] factor;
    logic [9:0]                   slots_i;

    assign h_ver      = head_data[20:19];
    assign h_lay      = head_data[18:17];
    assign h_bri      = head_data[15:12];
    assign h_fri      = head_data[11:10];
    assign h_sync_ok  = (head_data[31:21] == 11'h7FF);
    assign h_reserved = (h_ver == madh_pkg::VER_RESERVED) || (h_lay == madh_pkg::LAY_RESERVED)
                     || (h_bri == madh_pkg::BRI_RESERVED) || (h_fri == madh_pkg::FRI_RESERVED);

    // Pick the bitrate row from version and layer
    always_comb begin
        if (h_ver == madh_pkg::VER_MPEG1) begin
            h_row = {1'b0, 2'd3 - h_lay};
        end else if (h_lay == madh_pkg::LAY_I) begin
            h_row = 3'd3;
        end else begin
            h_row = 3'd4;
        end
    end

    assign h_br = ((h_ver != madh_pkg::VER_RESERVED) && (h_lay != madh_pkg::LAY_RESERVED))
                ? madh_pkg::KBPS_ROWS[h_row][h_bri] : '0;
    assign h_fr = madh_pkg::HZ_ROWS[h_ver][h_fri];
    assign h_need_div = h_sync_ok && !h_reserved && (h_br != '0) && (h_fr != '0);

    assign rem_try = {rem_reg, prod_reg[PROD_W-1]};
    assign rem_ge  = (rem_try >= {1'b0, fr_reg});
    assign factor  = (lay_reg == madh_pkg::LAY_I) ? madh_pkg::FACTOR_LAYER_I
                                                  : madh_pkg::FACTOR_OTHER;
    assign slots_i = quo_reg[9:0] + {9'd0, flags_reg[1]};

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            madh_pkg::BK_IDLE: begin
                if (!q_stat.empty) begin
                    state_next = h_need_div ? madh_pkg::BK_MUL : madh_pkg::BK_DONE;
                end
            end
            madh_pkg::BK_MUL: begin
                state_next = madh_pkg::BK_DIV;
            end
            madh_pkg::BK_DIV: begin
                if (step_reg == STEP_W'(PROD_W - 1)) begin
                    state_next = madh_pkg::BK_LEN;
                end
            end
            madh_pkg::BK_LEN: begin
                state_next = madh_pkg::BK_DONE;
            end
            madh_pkg::BK_DONE: begin
                if (m_ready) begin
                    state_next = madh_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = madh_pkg::BK_IDLE;
            end
        endcase
    end

    // Handshake outputs
    always_comb begin
        pop     = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            madh_pkg::BK_IDLE: begin
                pop = !q_stat.empty;
            end
            madh_pkg::BK_DONE: begin
                m_valid = 1'b1;
            end
            default: begin
                pop     = 1'b0;
                m_valid = 1'b0;
            end
        endcase
    end

    // Datapath: capture fields, multiply, divide one bit per cycle, form length
    always_comb begin
        status_next = status_reg;
        ver_next    = ver_reg;
        lay_next    = lay_reg;
        br_next     = br_reg;
        fr_next     = fr_reg;
        cm_next     = cm_reg;
        me_next     = me_reg;
        emph_next   = emph_reg;
        flags_next  = flags_reg;
        len_next    = len_reg;
        prod_next   = prod_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        step_next   = step_reg;
        case (state_reg)
            madh_pkg::BK_IDLE: begin
                len_next = '0;
                if (h_sync_ok) begin
                    status_next = h_reserved ? madh_pkg::ST_RESERVED : madh_pkg::ST_OK;
                    ver_next    = h_ver;
                    lay_next    = h_lay;
                    br_next     = h_br;
                    fr_next     = h_fr;
                    cm_next     = head_data[7:6];
                    me_next     = head_data[5:4];
                    emph_next   = head_data[1:0];
                    flags_next  = {head_data[2], head_data[3], head_data[8],
                                   head_data[9], head_data[16]};
                end else begin
                    status_next = madh_pkg::ST_BAD_SYNC;
                    ver_next    = '0;
                    lay_next    = '0;
                    br_next     = '0;
                    fr_next     = '0;
                    cm_next     = '0;
                    me_next     = '0;
                    emph_next   = '0;
                    flags_next  = '0;
                end
            end
            madh_pkg::BK_MUL: begin
                prod_next = factor * br_reg;
                rem_next  = '0;
                quo_next  = '0;
                step_next = '0;
            end
            madh_pkg::BK_DIV: begin
                prod_next = {prod_reg[PROD_W-2:0], 1'b0};
                rem_next  = rem_ge ? HZ_W'(rem_try - {1'b0, fr_reg}) : rem_try[HZ_W-1:0];
                quo_next  = {quo_reg[madh_pkg::LEN_W-2:0], rem_ge};
                step_next = step_reg + 1'b1;
            end
            madh_pkg::BK_LEN: begin
                if (lay_reg == madh_pkg::LAY_I) begin
                    len_next = {slots_i, 2'b00};
                end else begin
                    len_next = quo_reg + {11'd0, flags_reg[1]};
                end
            end
            default: begin
                len_next = len_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= madh_pkg::BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
        status_reg <= status_next;
        ver_reg    <= ver_next;
        lay_reg    <= lay_next;
        br_reg     <= br_next;
        fr_reg     <= fr_next;
        cm_reg     <= cm_next;
        me_reg     <= me_next;
        emph_reg   <= emph_next;
        flags_reg  <= flags_next;
        len_reg    <= len_next;
        prod_reg   <= prod_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        step_reg   <= step_next;
    end

    assign m_status         = status_reg;
    assign m_version_code   = ver_reg;
    assign m_layer_code     = lay_reg;
    assign m_bitrate_kbps   = br_reg;
    assign m_sample_rate_hz = fr_reg;
    assign m_channel_mode   = cm_reg;
    assign m_mode_extension = me_reg;
    assign m_emphasis       = emph_reg;
    assign m_flag_bits      = flags_reg;
    assign m_frame_bytes    = len_reg;

endmodule

@@ tb/sv/mpeg_audio_header_decoder_test.sv @@
`timescale 1ns / 100ps
// Self-checking bench for mpeg_audio_header_decoder: byte stream in, decoded header out.
// Depends on madh_pkg and the block itself; predicts every result and checks it in order.
module mpeg_audio_header_decoder_test;

    localparam int unsigned STREAM_BYTES = 2000;
    localparam int unsigned STALL_LIMIT  = 4000;
    localparam int unsigned DRAIN_CYCLES = 40;

    // Bitrate rows: MPEG-1 I, II, III; MPEG-2/2.5 I; MPEG-2/2.5 II and III
    localparam logic [8:0] BITRATE_TBL [5][16] = '{
        '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
          9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
        '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
          9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
        '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
          9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
        '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
          9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
        '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
          9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
    };

    // Sample rates by version code, then rate index
    localparam logic [15:0] SAMPLE_RATE_TBL [4][4] = '{
        '{16'd11025, 16'd12000, 16'd8000, 16'd0},
        '{16'd0, 16'd0, 16'd0, 16'd0},
        '{16'd22050, 16'd24000, 16'd16000, 16'd0},
        '{16'd44100, 16'd48000, 16'd32000, 16'd0}
    };

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  version_code;
        logic [1:0]  layer_code;
        logic [8:0]  bitrate_kbps;
        logic [15:0] sample_rate_hz;
        logic [1:0]  channel_mode;
        logic [1:0]  mode_extension;
        logic [1:0]  emphasis;
        logic [4:0]  flag_bits;
        logic [11:0] frame_bytes;
    } frame_info_t;

    // Tracks the header collector and holds the decoded frames still owed by the block
    class frame_tracker;
        int unsigned   held_bytes;
        logic [23:0]   partial_header;
        frame_info_t   owed_frames[$];
        int unsigned   mismatches;

        function automatic frame_info_t decode_header(logic [31:0] h);
            frame_info_t fi;
            logic [1:0]  ver;
            logic [1:0]  lay;
            logic [3:0]  bri;
            logic [1:0]  fri;
            int unsigned pad;
            int unsigned row;
            int unsigned kbps;
            int unsigned hz;
            int unsigned len;
            bit          reserved;
            fi = '0;
            // Bad sync: everything but the status stays zero
            if (h[31:21] != 11'h7FF) begin
                fi.status = madh_pkg::ST_BAD_SYNC;
                return fi;
            end
            ver  = h[20:19];
            lay  = h[18:17];
            bri  = h[15:12];
            fri  = h[11:10];
            pad  = h[9];
            kbps = 0;
            len  = 0;
            if (ver != madh_pkg::VER_RESERVED && lay != madh_pkg::LAY_RESERVED) begin
                if (ver == madh_pkg::VER_MPEG1)
                    row = 3 - lay;
                else
                    row = (lay == madh_pkg::LAY_I) ? 3 : 4;
                kbps = BITRATE_TBL[row][bri];
            end
            hz = SAMPLE_RATE_TBL[ver][fri];
            reserved = (ver == madh_pkg::VER_RESERVED) || (lay == madh_pkg::LAY_RESERVED)
                    || (bri == madh_pkg::BRI_RESERVED) || (fri == madh_pkg::FRI_RESERVED);
            if (!reserved && kbps != 0 && hz != 0) begin
                if (lay == madh_pkg::LAY_I)
                    len = 4 * ((12000 * kbps) / hz + pad);
                else
                    len = (144000 * kbps) / hz + pad;
            end
            fi.status         = reserved ? madh_pkg::ST_RESERVED : madh_pkg::ST_OK;
            fi.version_code   = ver;
            fi.layer_code     = lay;
            fi.bitrate_kbps   = kbps[8:0];
            fi.sample_rate_hz = hz[15:0];
            fi.channel_mode   = h[7:6];
            fi.mode_extension = h[5:4];
            fi.emphasis       = h[1:0];
            fi.flag_bits      = {h[2], h[3], h[8], h[9], h[16]};
            fi.frame_bytes    = len[11:0];
            return fi;
        endfunction

        // Advance the collector by one accepted stream byte
        function void take_byte(logic [7:0] b);
            if (held_bytes == 0) begin
                if (b == madh_pkg::SYNC_BYTE) begin
                    partial_header = {16'h0, b};
                    held_bytes = 1;
                end
            end else if (held_bytes < 3) begin
                partial_header = {partial_header[15:0], b};
                held_bytes++;
            end else begin
                owed_frames.push_back(decode_header({partial_header, b}));
                held_bytes = 0;
            end
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        // Compare one accepted result against the oldest owed frame
        function void compare_frame(frame_info_t got);
            frame_info_t want;
            if (owed_frames.size() == 0) begin
                $error("result with no header pending");
                mismatches++;
                return;
            end
            want = owed_frames.pop_front();
            check_field("status", want.status, got.status);
            check_field("version_code", want.version_code, got.version_code);
            check_field("layer_code", want.layer_code, got.layer_code);
            check_field("bitrate_kbps", want.bitrate_kbps, got.bitrate_kbps);
            check_field("sample_rate_hz", want.sample_rate_hz, got.sample_rate_hz);
            check_field("channel_mode", want.channel_mode, got.channel_mode);
            check_field("mode_extension", want.mode_extension, got.mode_extension);
            check_field("emphasis", want.emphasis, got.emphasis);
            check_field("flag_bits", want.flag_bits, got.flag_bits);
            check_field("frame_bytes", want.frame_bytes, got.frame_bytes);
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [1:0]  m_version_code;
    logic [1:0]  m_layer_code;
    logic [8:0]  m_bitrate_kbps;
    logic [15:0] m_sample_rate_hz;
    logic [1:0]  m_channel_mode;
    logic [1:0]  m_mode_extension;
    logic [1:0]  m_emphasis;
    logic [4:0]  m_flag_bits;
    logic [11:0] m_frame_bytes;

    frame_tracker frames = new();
    bit           steady = 1'b0;
    int unsigned  quiet_cycles = 0;

    mpeg_audio_header_decoder i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_version_code   (m_version_code),
        .m_layer_code     (m_layer_code),
        .m_bitrate_kbps   (m_bitrate_kbps),
        .m_sample_rate_hz (m_sample_rate_hz),
        .m_channel_mode   (m_channel_mode),
        .m_mode_extension (m_mode_extension),
        .m_emphasis       (m_emphasis),
        .m_flag_bits      (m_flag_bits),
        .m_frame_bytes    (m_frame_bytes)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Mostly short idles, a few long ones, none while the steady stretch lasts
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one byte request, hold it until taken, then idle for a while
    task automatic drive_byte(input logic [7:0] b);
        int unsigned gap;
        s_valid     <= 1'b1;
        s_data_byte <= b;
        do
            @(posedge aclk);
        while (!s_ready);
        gap = idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drive_header(input logic [7:0] b0, b1, b2, b3);
        drive_byte(b0);
        drive_byte(b1);
        drive_byte(b2);
        drive_byte(b3);
    endtask

    // Stall the result side at random
    initial begin
        int unsigned stall;
        @(posedge aclk);
        forever begin
            stall = idle_len();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    end

    // Predict on accepted requests, check accepted results
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                frames.take_byte(s_data_byte);
            if (m_valid && m_ready)
                frames.compare_frame(frame_info_t'({m_status, m_version_code, m_layer_code,
                    m_bitrate_kbps, m_sample_rate_hz, m_channel_mode, m_mode_extension,
                    m_emphasis, m_flag_bits, m_frame_bytes}));
        end
    end

    // Abort when nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int unsigned header_bytes_sent;
        logic [7:0]  second;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: dropped bytes, then one header per special case
        drive_byte(8'h00);
        drive_byte(8'h7F);
        drive_header(8'hFF, 8'hFB, 8'h90, 8'h64);  // MPEG-1 layer III, plain
        drive_header(8'hFF, 8'h00, 8'h00, 8'h00);  // bad sync
        drive_header(8'hFF, 8'hFF, 8'hFF, 8'hFF);  // sync bytes inside, bitrate and rate codes reserved
        drive_header(8'hFF, 8'hFF, 8'hEA, 8'h00);  // layer I, top bitrate, padded
        drive_header(8'hFF, 8'hE2, 8'h08, 8'hDF);  // MPEG-2.5 free format
        drive_header(8'hFF, 8'hEB, 8'h12, 8'h2C);  // reserved version

        // Random: mostly synced headers with random content, some stray bytes
        header_bytes_sent = 0;
        while (header_bytes_sent < STREAM_BYTES) begin
            if ($urandom_range(0, 19) == 0)
                steady = ~steady;
            if ($urandom_range(0, 4) != 0) begin
                if ($urandom_range(0, 9) == 0)
                    second = 8'($urandom);
                else
                    second = {3'b111, 5'($urandom)};
                drive_header(madh_pkg::SYNC_BYTE, second, 8'($urandom), 8'($urandom));
                header_bytes_sent += 4;
            end else begin
                repeat ($urandom_range(1, 4))
                    drive_byte(($urandom_range(0, 4) == 0) ? madh_pkg::SYNC_BYTE
                                                           : 8'($urandom));
            end
        end
        s_valid <= 1'b0;

        // Drain the owed results, then watch for strays
        while (frames.owed_frames.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (frames.mismatches == 0 && frames.owed_frames.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
